@@ sv/assert_macros.svh @@
// Assertion macros shared by the integer ALU RTL.
// Each macro checks on the rising edge of clk; IBALU_ASSERT is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, reports through $error.
`define IBALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that does not stop at reset.
`define IBALU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ibalu_pkg.sv @@
// Shared constants and types for the integer ALU.
// Used by ibalu_divu and integer_binary_op_alu; depends on nothing.
package ibalu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef enum logic [3:0] {
    OP_MUL = 4'd0,
    OP_OR  = 4'd1,
    OP_XOR = 4'd2,
    OP_AND = 4'd3,
    OP_SHL = 4'd4,
    OP_SHR = 4'd5,
    OP_MOD = 4'd6,
    OP_DIV = 4'd7,
    OP_SUB = 4'd8,
    OP_POW = 4'd9,
    OP_ADD = 4'd10
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DIV0 = 2'd1,
    ERR_NEG  = 2'd2
  } err_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ sv/ibalu_divu.sv @@
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on ibalu_pkg.
`include "assert_macros.svh"

module ibalu_divu (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ibalu_pkg::DATA_WIDTH-1:0]  dividend,
  input  logic [ibalu_pkg::DATA_WIDTH-1:0]  divisor,
  output ibalu_pkg::div_status_t            status,
  output logic [ibalu_pkg::DATA_WIDTH-1:0]  quotient,
  output logic [ibalu_pkg::DATA_WIDTH-1:0]  remainder
);

  logic [ibalu_pkg::CNT_W-1:0]      count;
  logic [ibalu_pkg::DATA_WIDTH-1:0] q;
  logic [ibalu_pkg::DATA_WIDTH-1:0] rem;
  logic [ibalu_pkg::DATA_WIDTH-1:0] dvsr;
  logic                             busy;
  logic                             done;
  logic [ibalu_pkg::DATA_WIDTH:0]   trial;

  assign trial = {rem, q[ibalu_pkg::DATA_WIDTH-1]} - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= ibalu_pkg::CNT_W'(ibalu_pkg::DATA_WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == ibalu_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q    <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      if (!trial[ibalu_pkg::DATA_WIDTH]) begin
        rem <= trial[ibalu_pkg::DATA_WIDTH-1:0];
        q   <= {q[ibalu_pkg::DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[ibalu_pkg::DATA_WIDTH-2:0], q[ibalu_pkg::DATA_WIDTH-1]};
        q   <= {q[ibalu_pkg::DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = q;
  assign remainder   = rem;

  `IBALU_ASSERT(a_done_after_busy, done |-> $past(busy), "divider done without work")
  `IBALU_ASSERT(a_not_both, !(busy && done), "divider busy and done together")
  `IBALU_ASSERT(a_count_live, busy |-> count != '0, "divider busy with zero count")

endmodule

@@ sv/integer_binary_op_alu.sv @@
// Integer ALU for a bytecode machine: one request gives one wrapped 32-bit result and an
// error code. Logic ops, add, sub, shifts and multiply present their result in the cycle
// after the request is taken, as do divide-by-zero and negative shift or exponent errors.
// Divide and modulo load the divider, run its one-bit-per-cycle steps and sign the result.
// Power alternates multiply and square on the single shared multiplier, one of each per
// exponent bit up to its highest set bit, then writes the result.
// One request is in flight at a time. Depends on ibalu_pkg and ibalu_divu.
`include "assert_macros.svh"

module integer_binary_op_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic signed [31:0] left_operand,
  input  logic signed [31:0] right_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] result_value,
  output logic [1:0]  error_code
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_PMUL = 4'b0100,
    S_PSQR = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [31:0] acc, base, expo;
  logic        is_mod, neg_l, neg_q;
  logic        accept;
  logic [31:0] mul_a, mul_b, prod;
  logic [63:0] prod_full;
  logic [31:0] mag_l, mag_r, div_q, div_r;
  logic        div_start;
  ibalu_pkg::div_status_t div_st;
  logic [31:0] quick_res;
  logic [1:0]  quick_err;
  logic        quick_done;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (state)
      S_PSQR:  begin mul_a = base;         mul_b = base; end
      S_PMUL:  begin mul_a = acc;          mul_b = base; end
      default: begin mul_a = left_operand; mul_b = right_operand; end
    endcase
  end
  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[31:0];

  assign mag_l = left_operand[31]  ? -left_operand  : left_operand;
  assign mag_r = right_operand[31] ? -right_operand : right_operand;

  // Combinational results for the quick ops and the error checks; divide and power only set up here.
  always_comb begin
    quick_res  = '0;
    quick_err  = ibalu_pkg::ERR_NONE;
    quick_done = 1'b1;
    div_start  = 1'b0;
    case (opcode)
      ibalu_pkg::OP_MUL: quick_res = prod;
      ibalu_pkg::OP_OR:  quick_res = left_operand | right_operand;
      ibalu_pkg::OP_XOR: quick_res = left_operand ^ right_operand;
      ibalu_pkg::OP_AND: quick_res = left_operand & right_operand;
      ibalu_pkg::OP_ADD: quick_res = left_operand + right_operand;
      ibalu_pkg::OP_SUB: quick_res = left_operand - right_operand;
      ibalu_pkg::OP_SHL: begin
        if (right_operand[31])         quick_err = ibalu_pkg::ERR_NEG;
        else if (right_operand >= 32)  quick_res = '0;
        else                           quick_res = left_operand << right_operand[4:0];
      end
      ibalu_pkg::OP_SHR: begin
        if (right_operand[31])         quick_err = ibalu_pkg::ERR_NEG;
        else if (right_operand >= 32)  quick_res = {32{left_operand[31]}};
        else                           quick_res = left_operand >>> right_operand[4:0];
      end
      ibalu_pkg::OP_MOD, ibalu_pkg::OP_DIV: begin
        if (right_operand == '0) begin
          quick_err = ibalu_pkg::ERR_DIV0;
        end else begin
          quick_done = 1'b0;
          div_start  = accept;
        end
      end
      ibalu_pkg::OP_POW: begin
        if (right_operand[31]) quick_err = ibalu_pkg::ERR_NEG;
        else                   quick_done = 1'b0;
      end
      default: quick_res = '0;
    endcase
  end

  ibalu_divu u_divu (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag_l),
    .divisor   (mag_r),
    .status    (div_st),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !quick_done)
          state_next = (opcode == ibalu_pkg::OP_POW) ? S_PMUL : S_DIV;
      end
      S_DIV:   if (div_st.done) state_next = S_IDLE;
      S_PMUL:  if (expo != '0) state_next = S_PSQR; else state_next = S_IDLE;
      S_PSQR:  state_next = S_PMUL;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall)
        out_valid <= 1'b0;
      else if ((state == S_IDLE && accept && quick_done) ||
               (state == S_DIV && div_st.done) ||
               (state == S_PMUL && expo == '0))
        out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          result_value <= quick_res;
          error_code   <= quick_err;
          is_mod       <= (opcode == ibalu_pkg::OP_MOD);
          neg_l        <= left_operand[31];
          neg_q        <= left_operand[31] ^ right_operand[31];
          acc          <= 32'd1;
          base         <= left_operand;
          expo         <= right_operand;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          if (is_mod) result_value <= neg_l ? -div_r : div_r;
          else        result_value <= neg_q ? -div_q : div_q;
        end
      end
      S_PMUL: begin
        if (expo == '0) result_value <= acc;
        else if (expo[0]) acc <= prod;
      end
      S_PSQR: begin
        base <= prod;
        expo <= expo >> 1;
      end
      default: ;
    endcase
  end

  `IBALU_ASSERT(a_err_zero, out_valid && error_code != ibalu_pkg::ERR_NONE |-> result_value == '0, "error result not zero")
  `IBALU_ASSERT(a_accept_busy, accept |=> (state != S_IDLE) || out_valid, "request dropped")
  `IBALU_ASSERT(a_div_state, div_st.done |-> state == S_DIV, "divider done outside divide")
  `IBALU_ASSERT_ALWAYS(a_rst_idle, rst |=> state == S_IDLE && !out_valid, "reset not idle")

endmodule
